>>> hdl/bpt_pkg.sv
// ============================================================================
// bpt_pkg
// Shared types and constants for the barycentric point-in-triangle pipeline.
// ============================================================================
package bpt_pkg;

    localparam int unsigned WEIGHT_W = 32;   // output weight width
    localparam int unsigned QUOT_W   = 32;   // quotient bits built by the divider

    typedef enum logic [1:0] {
        ST_INSIDE  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_DEGEN   = 2'd2
    } t_status;

    // Per-request flags that ride alongside the divider stages.
    typedef struct packed {
        logic degen;    // zero determinant
        logic outside;  // some numerator has the wrong sign
        logic neg_c;    // weight_c is negative
        logic neg_b;    // weight_b is negative
        logic ovf_c;    // |weight_c| quotient reached 2^32
        logic ovf_b;
    } t_side;

endpackage

>>> hdl/bpt_front.sv
// ============================================================================
// bpt_front
// Edge vectors, products, cross terms, signs and divider setup (5 stages).
// ============================================================================
module bpt_front #(
    parameter int COORD_WIDTH      = 24,
    parameter int WEIGHT_FRAC_BITS = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output logic                          o_valid,
    output logic [2*COORD_WIDTH+35:0]     o_rem_c,
    output logic [2*COORD_WIDTH+35:0]     o_rem_b,
    output logic [2*COORD_WIDTH+1:0]      o_den,
    output bpt_pkg::t_side                o_side
);
    import bpt_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // edge vector width
    localparam int PW = 2 * DW;            // product width
    localparam int XW = PW + 1;            // cross term width
    localparam int MW = XW - 1;            // magnitude width
    localparam int RW = MW + 34;           // remainder width

    logic [4:0] r_valid;

    // stage 1: edge vectors
    logic signed [DW-1:0] r_v0x, r_v0y, r_v1x, r_v1y, r_v2x, r_v2y;
    // stage 2: products
    logic signed [PW-1:0] r_p_d0, r_p_d1, r_p_c0, r_p_c1, r_p_b0, r_p_b1;
    // stage 3: cross terms
    logic signed [XW-1:0] r_d, r_n1, r_n2;
    // stage 4: magnitudes and flags
    logic [MW-1:0] r_mag_d, r_mag_c, r_mag_b;
    t_side         r_side4;
    // stage 5: divider setup
    logic [RW-1:0] r_rem_c, r_rem_b;
    logic [MW-1:0] r_den;
    t_side         r_side5;

    logic signed [XW+1:0] n3;
    logic                 d_neg;
    logic                 neg_c, neg_b, neg_a;
    logic [RW-1:0]        n_rem_c, n_rem_b, den_top;
    t_side                n_side5;

    function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] t;
        t = x[XW-1] ? -x : x;
        return t[MW-1:0];
    endfunction

    always_comb begin
        n3    = {{2{r_d[XW-1]}}, r_d} - {{2{r_n1[XW-1]}}, r_n1}
                - {{2{r_n2[XW-1]}}, r_n2};
        d_neg = r_d[XW-1];
        // sign after normalizing the determinant to positive
        neg_c = d_neg ? (!r_n1[XW-1] && (r_n1 != '0)) : r_n1[XW-1];
        neg_b = d_neg ? (!r_n2[XW-1] && (r_n2 != '0)) : r_n2[XW-1];
        neg_a = d_neg ? (!n3[XW+1] && (n3 != '0)) : n3[XW+1];
    end

    always_comb begin
        n_rem_c       = RW'(r_mag_c) << WEIGHT_FRAC_BITS;
        n_rem_b       = RW'(r_mag_b) << WEIGHT_FRAC_BITS;
        den_top       = RW'(r_mag_d) << QUOT_W;
        n_side5       = r_side4;
        n_side5.ovf_c = (n_rem_c >= den_top);
        n_side5.ovf_b = (n_rem_b >= den_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0x <= $signed({i_cx[COORD_WIDTH-1], i_cx}) - $signed({i_ax[COORD_WIDTH-1], i_ax});
            r_v0y <= $signed({i_cy[COORD_WIDTH-1], i_cy}) - $signed({i_ay[COORD_WIDTH-1], i_ay});
            r_v1x <= $signed({i_bx[COORD_WIDTH-1], i_bx}) - $signed({i_ax[COORD_WIDTH-1], i_ax});
            r_v1y <= $signed({i_by[COORD_WIDTH-1], i_by}) - $signed({i_ay[COORD_WIDTH-1], i_ay});
            r_v2x <= $signed({i_px[COORD_WIDTH-1], i_px}) - $signed({i_ax[COORD_WIDTH-1], i_ax});
            r_v2y <= $signed({i_py[COORD_WIDTH-1], i_py}) - $signed({i_ay[COORD_WIDTH-1], i_ay});

            r_p_d0 <= r_v0x * r_v1y;
            r_p_d1 <= r_v0y * r_v1x;
            r_p_c0 <= r_v2x * r_v1y;
            r_p_c1 <= r_v2y * r_v1x;
            r_p_b0 <= r_v0x * r_v2y;
            r_p_b1 <= r_v0y * r_v2x;

            r_d  <= $signed({r_p_d0[PW-1], r_p_d0}) - $signed({r_p_d1[PW-1], r_p_d1});
            r_n1 <= $signed({r_p_c0[PW-1], r_p_c0}) - $signed({r_p_c1[PW-1], r_p_c1});
            r_n2 <= $signed({r_p_b0[PW-1], r_p_b0}) - $signed({r_p_b1[PW-1], r_p_b1});

            r_mag_d         <= mag(r_d);
            r_mag_c         <= mag(r_n1);
            r_mag_b         <= mag(r_n2);
            r_side4.degen   <= (r_d == '0);
            r_side4.outside <= neg_c || neg_b || neg_a;
            r_side4.neg_c   <= neg_c;
            r_side4.neg_b   <= neg_b;
            r_side4.ovf_c   <= 1'b0;
            r_side4.ovf_b   <= 1'b0;

            r_rem_c <= n_rem_c;
            r_rem_b <= n_rem_b;
            r_den   <= r_mag_d;
            r_side5 <= n_side5;
        end
    end

    assign o_valid = r_valid[4];
    assign o_rem_c = r_rem_c;
    assign o_rem_b = r_rem_b;
    assign o_den   = r_den;
    assign o_side  = r_side5;

endmodule

>>> hdl/bpt_div_step.sv
// ============================================================================
// bpt_div_step
// One registered restoring-division step: resolves one quotient bit.
// ============================================================================
module bpt_div_step #(
    parameter int RW  = 84,
    parameter int MW  = 50,
    parameter int BIT = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [MW-1:0] i_den,
    input  logic [31:0]   i_quot,
    output logic [RW-1:0] o_rem,
    output logic [MW-1:0] o_den,
    output logic [31:0]   o_quot
);
    logic [RW-1:0] trial;
    logic          fits;
    logic [31:0]   n_quot;
    logic [RW-1:0] r_rem;
    logic [MW-1:0] r_den;
    logic [31:0]   r_quot;

    assign trial = RW'(i_den) << BIT;
    assign fits  = (i_rem >= trial);

    always_comb begin
        n_quot      = i_quot;
        n_quot[BIT] = fits;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= fits ? (i_rem - trial) : i_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quot = r_quot;

endmodule

>>> hdl/bpt_back.sv
// ============================================================================
// bpt_back
// Signs, saturation, weight_a and status; output register.
// ============================================================================
module bpt_back #(
    parameter int WEIGHT_FRAC_BITS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_quot_c,
    input  logic [31:0]           i_quot_b,
    input  bpt_pkg::t_side        i_side,
    output logic                  o_valid,
    output bpt_pkg::t_status      o_status,
    output logic signed [31:0]    o_weight_c,
    output logic signed [31:0]    o_weight_b,
    output logic signed [31:0]    o_weight_a
);
    import bpt_pkg::*;

    localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [33:0] ONE   = 34'sd1 <<< WEIGHT_FRAC_BITS;

    logic                r_valid;
    t_status             r_status;
    logic signed [31:0]  r_wc, r_wb, r_wa;
    logic signed [31:0]  wc, wb, wa;
    logic signed [33:0]  sum_a;

    function automatic logic signed [31:0] sat_w(input logic [31:0] q, input logic neg,
                                                 input logic ovf);
        logic signed [31:0] res;
        if (neg) begin
            res = (ovf || (q[31] && (q[30:0] != '0))) ? W_MIN : -$signed(q);
        end else begin
            res = (ovf || q[31]) ? W_MAX : $signed(q);
        end
        return res;
    endfunction

    always_comb begin
        wc    = sat_w(i_quot_c, i_side.neg_c, i_side.ovf_c);
        wb    = sat_w(i_quot_b, i_side.neg_b, i_side.ovf_b);
        sum_a = ONE - 34'(wc) - 34'(wb);
        if (sum_a > 34'(W_MAX)) begin
            wa = W_MAX;
        end else if (sum_a < 34'(W_MIN)) begin
            wa = W_MIN;
        end else begin
            wa = sum_a[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_side.degen) begin
                r_status <= ST_DEGEN;
                r_wc     <= '0;
                r_wb     <= '0;
                r_wa     <= '0;
            end else begin
                r_status <= i_side.outside ? ST_OUTSIDE : ST_INSIDE;
                r_wc     <= wc;
                r_wb     <= wb;
                r_wa     <= wa;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_weight_c = r_wc;
    assign o_weight_b = r_wb;
    assign o_weight_a = r_wa;

endmodule

>>> hdl/barycentric_point_in_triangle.sv
// ============================================================================
// barycentric_point_in_triangle
// Point-in-triangle test with barycentric weights, fully pipelined.
// ============================================================================
// Takes one request per cycle and returns one result per request, in order,
// through 5 front stages, 32 divider stages and 1 output stage.
// Throughput is one request per clock, set by the pipelined divider, which
// resolves one quotient bit per stage for weight_c and weight_b side by side.
// The whole pipe advances together; it holds only while a result sits in
// the output register and the sink stalls.
// Weights are Q2.30 (WEIGHT_FRAC_BITS), truncated toward zero and saturated;
// a zero determinant (collinear or repeated vertices) reports degenerate
// with all weights zero.
module barycentric_point_in_triangle #(
    parameter int COORD_WIDTH      = 24,
    parameter int WEIGHT_FRAC_BITS = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output bpt_pkg::t_status              o_status,
    output logic signed [31:0]            o_weight_c,
    output logic signed [31:0]            o_weight_b,
    output logic signed [31:0]            o_weight_a
);
    import bpt_pkg::*;

    localparam int MW = 2 * COORD_WIDTH + 2;   // cross term magnitude
    localparam int RW = MW + 34;               // divider remainder

    logic en;   // global pipeline advance

    logic          front_valid;
    t_side         front_side;

    logic [RW-1:0] rem_c [0:QUOT_W];
    logic [RW-1:0] rem_b [0:QUOT_W];
    logic [MW-1:0] den_c [0:QUOT_W];
    logic [MW-1:0] den_b [0:QUOT_W];
    logic [31:0]   quot_c [0:QUOT_W];
    logic [31:0]   quot_b [0:QUOT_W];

    logic [QUOT_W:1] r_valid_pipe;
    t_side           r_side_pipe [1:QUOT_W];
    t_side           side_tap [0:QUOT_W];

    // stall only when a finished result is held by the sink
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    bpt_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ax    (i_vertex_a_x),
        .i_ay    (i_vertex_a_y),
        .i_bx    (i_vertex_b_x),
        .i_by    (i_vertex_b_y),
        .i_cx    (i_vertex_c_x),
        .i_cy    (i_vertex_c_y),
        .i_px    (i_query_x),
        .i_py    (i_query_y),
        .o_valid (front_valid),
        .o_rem_c (rem_c[0]),
        .o_rem_b (rem_b[0]),
        .o_den   (den_c[0]),
        .o_side  (front_side)
    );

    assign den_b[0]    = den_c[0];
    assign quot_c[0]   = '0;
    assign quot_b[0]   = '0;
    assign side_tap[0] = front_side;

    // divider: stage j resolves quotient bit QUOT_W-1-j
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        bpt_div_step #(.RW(RW), .MW(MW), .BIT(QUOT_W - 1 - j)) u_step_c (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (rem_c[j]),
            .i_den  (den_c[j]),
            .i_quot (quot_c[j]),
            .o_rem  (rem_c[j+1]),
            .o_den  (den_c[j+1]),
            .o_quot (quot_c[j+1])
        );
        bpt_div_step #(.RW(RW), .MW(MW), .BIT(QUOT_W - 1 - j)) u_step_b (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (rem_b[j]),
            .i_den  (den_b[j]),
            .i_quot (quot_b[j]),
            .o_rem  (rem_b[j+1]),
            .o_den  (den_b[j+1]),
            .o_quot (quot_b[j+1])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side_pipe[j+1] <= side_tap[j];
            end
        end
        assign side_tap[j+1] = r_side_pipe[j+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_pipe <= '0;
        end else if (en) begin
            r_valid_pipe <= {r_valid_pipe[QUOT_W-1:1], front_valid};
        end
    end

    bpt_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_valid_pipe[QUOT_W]),
        .i_quot_c   (quot_c[QUOT_W]),
        .i_quot_b   (quot_b[QUOT_W]),
        .i_side     (side_tap[QUOT_W]),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_weight_c (o_weight_c),
        .o_weight_b (o_weight_b),
        .o_weight_a (o_weight_a)
    );

endmodule

>>> hdl/bpt_chk.sv
// ============================================================================
// bpt_chk
// Port-level checks for the point-in-triangle pipeline, bound to the top.
// ============================================================================
module bpt_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_stall,
    input logic                o_valid,
    input logic                o_stall,
    input bpt_pkg::t_status    o_status,
    input logic signed [31:0]  o_weight_c,
    input logic signed [31:0]  o_weight_b,
    input logic signed [31:0]  o_weight_a
);
    import bpt_pkg::*;

    // held result keeps its status and weight_c
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_weight_c) && $stable(o_status))
        else $error("held result changed");

    // degenerate results carry zero weights
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DEGEN) |->
            (o_weight_c == 0) && (o_weight_b == 0) && (o_weight_a == 0))
        else $error("degenerate result with nonzero weight");

    // inside results never have a negative weight
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_INSIDE) |->
            !o_weight_c[31] && !o_weight_b[31] && !o_weight_a[31])
        else $error("inside result with negative weight");

    // upstream held back only by a stalled result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without a held result");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind barycentric_point_in_triangle bpt_chk u_bpt_chk (.*);

>>> test/testbench.sv
// ============================================================================
// Barycentric point-in-triangle testbench
// Drives triangles and query points through the pipeline, predicts status and
// Q2.30 weights with exact wide integer math, and checks results in order.
// ============================================================================
class tri_scoreboard;
    typedef struct {
        bpt_pkg::t_status status;
        logic signed [31:0] wc;
        logic signed [31:0] wb;
        logic signed [31:0] wa;
    } t_weights;

    t_weights pending[$];
    int errors;
    int checked;
    int n_inside, n_outside, n_degen;

    // trunc(n * 2^30 / d), saturated to 32 bits signed; d > 0
    function logic signed [31:0] scaled_quot(logic signed [127:0] n,
                                             logic signed [127:0] d);
        logic signed [127:0] q;
        q = (n <<< 30) / d;
        if (q > 128'sd2147483647) return 32'sh7fffffff;
        if (q < -128'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    function void note_request(logic signed [23:0] ax, logic signed [23:0] ay,
                               logic signed [23:0] bx, logic signed [23:0] by,
                               logic signed [23:0] cx, logic signed [23:0] cy,
                               logic signed [23:0] px, logic signed [23:0] py);
        logic signed [127:0] v0x, v0y, v1x, v1y, v2x, v2y, det, n1, n2, n3, wa;
        t_weights w;
        v0x = cx - ax; v0y = cy - ay;
        v1x = bx - ax; v1y = by - ay;
        v2x = px - ax; v2y = py - ay;
        det = v0x * v1y - v0y * v1x;
        n1 = v2x * v1y - v2y * v1x;
        n2 = v0x * v2y - v0y * v2x;
        if (det == 0 || (ax == bx && ay == by) || (ax == cx && ay == cy)
                || (bx == cx && by == cy)) begin
            w.status = bpt_pkg::ST_DEGEN;
            w.wc = 0; w.wb = 0; w.wa = 0;
            n_degen++;
        end else begin
            n3 = det - n1 - n2;
            if (det < 0) begin
                det = -det; n1 = -n1; n2 = -n2; n3 = -n3;
            end
            w.wc = scaled_quot(n1, det);
            w.wb = scaled_quot(n2, det);
            wa = (128'sd1 <<< 30) - w.wc - w.wb;
            if (wa > 128'sd2147483647) wa = 128'sd2147483647;
            if (wa < -128'sd2147483648) wa = -128'sd2147483648;
            w.wa = wa[31:0];
            w.status = (n1 < 0 || n2 < 0 || n3 < 0) ? bpt_pkg::ST_OUTSIDE
                                                     : bpt_pkg::ST_INSIDE;
            if (w.status == bpt_pkg::ST_INSIDE) n_inside++;
            else n_outside++;
        end
        pending.push_back(w);
    endfunction

    function void check_result(bpt_pkg::t_status st, logic signed [31:0] wc,
                               logic signed [31:0] wb, logic signed [31:0] wa);
        t_weights e;
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result status=%0d", st);
            return;
        end
        e = pending.pop_front();
        if (st !== e.status || wc !== e.wc || wb !== e.wb || wa !== e.wa) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result %0d exp st=%0d c=%0d b=%0d a=%0d got st=%0d c=%0d b=%0d a=%0d",
                         checked, e.status, e.wc, e.wb, e.wa, st, wc, wb, wa);
        end
    endfunction
endclass

module testbench;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [23:0] ax = '0, ay = '0, bx = '0, by = '0;
    logic signed [23:0] cx = '0, cy = '0, px = '0, py = '0;
    logic               o_stall, o_valid;
    bpt_pkg::t_status   o_status;
    logic signed [31:0] o_weight_c, o_weight_b, o_weight_a;

    tri_scoreboard sb = new();
    int send_idle_pct = 0;   // sender gap chance, percent
    int sink_stall_pct = 0;  // receiver stall chance, percent
    int n_requests = 0;
    longint cycles = 0;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     PIPE_DRAIN = 60;  // full pipe depth plus margin

    always #5 i_clk = ~i_clk;

    barycentric_point_in_triangle dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_vertex_a_x(ax), .i_vertex_a_y(ay),
        .i_vertex_b_x(bx), .i_vertex_b_y(by),
        .i_vertex_c_x(cx), .i_vertex_c_y(cy),
        .i_query_x(px), .i_query_y(py),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_weight_c(o_weight_c),
        .o_weight_b(o_weight_b), .o_weight_a(o_weight_a)
    );

    // Result side: check on each accepted result, then pick the next stall.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_weight_c, o_weight_b, o_weight_a);
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Send one request; valid stays up until accepted, gaps only between.
    task automatic send_request(logic signed [23:0] a_x, logic signed [23:0] a_y,
                                logic signed [23:0] b_x, logic signed [23:0] b_y,
                                logic signed [23:0] c_x, logic signed [23:0] c_y,
                                logic signed [23:0] p_x, logic signed [23:0] p_y);
        ax <= a_x; ay <= a_y; bx <= b_x; by <= b_y;
        cx <= c_x; cy <= c_y; px <= p_x; py <= p_y;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y);
        n_requests++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0:       return 24'($urandom);                  // full range
            1:       return 24'($signed($urandom_range(8191)) - 4096);
            default: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    // Mostly sane triangles around a point, with some wild and extreme ones.
    task automatic send_random;
        int mode;
        logic signed [23:0] base_x, base_y;
        mode = $urandom_range(9);
        if (mode < 6) begin
            base_x = rand_coord(1) <<< $urandom_range(10);
            base_y = rand_coord(1) <<< $urandom_range(10);
            send_request(base_x + rand_coord(1), base_y + rand_coord(1),
                         base_x + rand_coord(1), base_y + rand_coord(1),
                         base_x + rand_coord(1), base_y + rand_coord(1),
                         base_x + rand_coord(1), base_y + rand_coord(1));
        end else if (mode == 6) begin
            // shared or collinear vertices
            base_x = rand_coord(0);
            base_y = rand_coord(0);
            send_request(base_x, base_y, base_x + 24'sd5, base_y + 24'sd7,
                         $urandom_range(1) ? base_x : base_x + 24'sd10,
                         $urandom_range(1) ? base_y : base_y + 24'sd14,
                         rand_coord(0), rand_coord(0));
        end else begin
            mode = (mode == 9) ? 2 : 0;
            send_request(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), rand_coord(mode), rand_coord(mode),
                         rand_coord(0), rand_coord(mode));
        end
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    localparam logic signed [23:0] MAXC = 24'sh7fffff;
    localparam logic signed [23:0] MINC = 24'sh800000;
    localparam logic signed [23:0] ONE  = 24'sd4096;  // 1.0 in Q12.12

    initial begin
        int phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unit triangle, inside, on edge, vertex, outside.
        send_request(0, 0, ONE, 0, 0, ONE, 1024, 1024);
        send_request(0, 0, ONE, 0, 0, ONE, 2048, 2048);    // on hypotenuse
        send_request(0, 0, ONE, 0, 0, ONE, 0, 0);          // at vertex A
        send_request(0, 0, ONE, 0, 0, ONE, ONE, ONE);      // outside
        send_request(0, 0, 0, ONE, ONE, 0, 1000, 500);     // clockwise winding
        // repeated vertices and collinear, all three pairings
        send_request(5, 5, 5, 5, 9, 1, 0, 0);
        send_request(5, 5, 9, 1, 5, 5, 0, 0);
        send_request(9, 1, 5, 5, 5, 5, 0, 0);
        send_request(0, 0, 1, 1, 2, 2, 3, 3);
        send_request(0, 0, 0, 0, 0, 0, 0, 0);
        // extremes: huge triangle, far points, saturating weights
        send_request(MINC, MINC, MAXC, MINC, MINC, MAXC, 0, 0);
        send_request(MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC);
        send_request(0, 0, 1, 0, 0, 1, MAXC, MAXC);
        send_request(0, 0, 1, 0, 0, 1, MINC, MINC);
        send_request(0, 0, 1, 0, 0, 1, MINC, MAXC);
        send_request(MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC, MINC);
        send_request(24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555,
                     24'sh000001, 24'shffffff, 24'sh123456, 24'shedcba9);

        // Pause until the pipe is empty, then random under three stall mixes.
        wait_drained();
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 35 : (phase == 1) ? 69 : 0;
            sink_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 35 : 0;
            repeat (170) send_random();
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (PIPE_DRAIN) @(posedge i_clk);

        $display("Sent %0d requests: %0d inside, %0d outside, %0d degenerate,",
                 n_requests, sb.n_inside, sb.n_outside, sb.n_degen);
        $display("under sender gaps and receiver stalls in both mixes and none.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/bpt_pkg.sv
hdl/bpt_front.sv
hdl/bpt_div_step.sv
hdl/bpt_back.sv
hdl/barycentric_point_in_triangle.sv
hdl/bpt_chk.sv
test/testbench.sv
